/* hw/rtl/rbd_pkg.sv */
// Shared definitions for the ring buffer deque: sizes, request and status codes,
// the control word driven into each cell chain, and data width conversions.
// No dependencies.
package rbd_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed field widths of the stream words
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL_PUSH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY_POP  = 2'd2;

    typedef logic [DATA_WIDTH-1:0] data_t;

    // one control word per chain, broadcast to every cell
    typedef struct packed {
        logic             shift_up;    // every cell takes its lower neighbor
        logic             shift_down;  // every cell takes its upper neighbor
        logic             load;        // the cell at load_index takes value
        logic [IDX_W-1:0] load_index;
        data_t            value;
    } rbd_chain_ctl_t;

    // sign-extend the input value, keep DATA_WIDTH bits
    function automatic data_t to_data(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[DATA_WIDTH-1:0];
    endfunction

    // report a stored value in the low bits of the output field
    function automatic logic [VALUE_W-1:0] to_out(input data_t d);
        logic [63:0] ext;
        ext = 64'(d);
        return ext[VALUE_W-1:0];
    endfunction

endpackage

/* hw/rtl/ring_buffer_deque_top.sv */
// Double-ended queue of DEPTH entries built from two chains of cells.
// Uses rbd_pkg and rbd_chain.
//
// Usage: each input word on the s_ channel carries one request (push front,
// push back, pop front, pop back, peek). Every accepted request yields
// exactly one output word on the m_ channel with the front and back values,
// occupancy, empty and full flags and a status (done, push refused because
// full, pop refused because empty). Front and back read as all ones while
// the queue is empty.
// Latency: the result word is valid the cycle after its request is taken.
// Throughput: one request per cycle. Two cell chains hold the contents, one
// ordered from the front and one from the back, so both end values sit in a
// fixed cell; a push at the far end of a chain is a decoded write at the
// cell matching the occupancy, and every other update is a one-cell shift.
// Reset (aresetn low at a clock edge): the queue becomes empty and no output
// word is pending; cell contents are not cleared and need no sweep.
// Stall: while an output word waits with m_tready low, s_tready is low and
// the state holds; a new request is taken in the same cycle the pending
// word is taken.
module ring_buffer_deque_top
    import rbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] req_type, [34:3] push_value, [39:35] zero
    input  logic [39:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] front_value, [63:32] back_value, [74:64] occupancy,
    // [75] is_empty, [76] is_full, [78:77] status, [79] zero
    output logic [79:0] m_tdata
);

    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] push_value;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;

    logic accept, full, empty;
    logic do_push_front, do_push_back, do_pop_front, do_pop_back;

    rbd_chain_ctl_t front_ctl, back_ctl;
    data_t          front_data, back_data;

    logic [VALUE_W-1:0] front_value, back_value;

    assign req_type   = s_tdata[REQ_W-1:0];
    assign push_value = s_tdata[REQ_W +: VALUE_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_pop_front  = 1'b0;
        do_pop_back   = 1'b0;
        status_next   = status_reg;
        if (accept) begin
            status_next = STATUS_DONE;
            unique case (req_type)
                REQ_PUSH_FRONT: begin
                    if (full) status_next = STATUS_FULL_PUSH;
                    else      do_push_front = 1'b1;
                end
                REQ_PUSH_BACK: begin
                    if (full) status_next = STATUS_FULL_PUSH;
                    else      do_push_back = 1'b1;
                end
                REQ_POP_FRONT: begin
                    if (empty) status_next = STATUS_EMPTY_POP;
                    else       do_pop_front = 1'b1;
                end
                REQ_POP_BACK: begin
                    if (empty) status_next = STATUS_EMPTY_POP;
                    else       do_pop_back = 1'b1;
                end
                REQ_PEEK: begin
                    status_next = STATUS_DONE;
                end
                default: begin
                    // unused codes act as peek
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_push_front || do_push_back) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop_front || do_pop_back) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // front-ordered chain shifts on front traffic, takes back pushes by index
    always_comb begin
        front_ctl.shift_up   = do_push_front;
        front_ctl.shift_down = do_pop_front;
        front_ctl.load       = do_push_back;
        front_ctl.load_index = count_reg[IDX_W-1:0];
        front_ctl.value      = to_data(push_value);

        back_ctl.shift_up    = do_push_back;
        back_ctl.shift_down  = do_pop_back;
        back_ctl.load        = do_push_front;
        back_ctl.load_index  = count_reg[IDX_W-1:0];
        back_ctl.value       = to_data(push_value);
    end

    rbd_chain u_front_chain (
        .aclk     (aclk),
        .ctl      (front_ctl),
        .end_data (front_data)
    );

    rbd_chain u_back_chain (
        .aclk     (aclk),
        .ctl      (back_ctl),
        .end_data (back_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            status_reg  <= STATUS_DONE;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // state holds while a word is pending, so the result reads straight from it
    assign front_value = empty ? '1 : to_out(front_data);
    assign back_value  = empty ? '1 : to_out(back_data);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, status_reg, full, empty, OCC_W'(count_reg),
                       back_value, front_value};

endmodule

/* hw/rtl/rbd_cell.sv */
// One storage cell of a deque chain: holds one entry, shifts toward either
// neighbor or loads a pushed value at its own position. Uses rbd_pkg.
module rbd_cell
    import rbd_pkg::*;
(
    input  logic             aclk,
    input  rbd_chain_ctl_t   ctl,
    input  logic [IDX_W-1:0] cell_index,
    input  data_t            lower_data,
    input  data_t            upper_data,
    output data_t            cell_data
);

    data_t data_reg;
    data_t data_next;

    always_comb begin
        unique if (ctl.shift_up) begin
            data_next = lower_data;
        end else if (ctl.shift_down) begin
            data_next = upper_data;
        end else if (ctl.load && (ctl.load_index == cell_index)) begin
            data_next = ctl.value;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;

endmodule

/* hw/rtl/rbd_chain.sv */
// Row of DEPTH cells ordered from one end of the deque; cell 0 is the end
// entry. Uses rbd_pkg and rbd_cell.
module rbd_chain
    import rbd_pkg::*;
(
    input  logic           aclk,
    input  rbd_chain_ctl_t ctl,
    output data_t          end_data
);

    data_t cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        data_t lower_data;
        data_t upper_data;

        if (i == 0) begin : g_first
            assign lower_data = ctl.value;
        end else begin : g_mid_lo
            assign lower_data = cell_data[i-1];
        end

        // the far cell holds on a shift down; it lies outside the occupied span
        if (i == DEPTH - 1) begin : g_last
            assign upper_data = cell_data[i];
        end else begin : g_mid_hi
            assign upper_data = cell_data[i+1];
        end

        rbd_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .cell_index (IDX_W'(i)),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .cell_data  (cell_data[i])
        );
    end

    assign end_data = cell_data[0];

endmodule
